// ----- design/klein_bottle_point_eval_macros.svh -----
// Assertion macros for the Klein bottle point evaluator.
// Used by klein_bottle_point_eval.sv; expects clk and arst_n in scope.
`ifndef KLEIN_BOTTLE_POINT_EVAL_MACROS_SVH
`define KLEIN_BOTTLE_POINT_EVAL_MACROS_SVH

// same-cycle implication
`define KB_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define KB_ASSERT_NXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- design/kbpe_pkg.sv -----
`timescale 1ns / 1ps
// Package for the Klein bottle point evaluator: widths, CORDIC constants,
// lane type and arithmetic helpers. No dependencies.
package kbpe_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_ITERS = 20;
	localparam int TRIG_Q       = 30;
	localparam int ROUND_SHIFT  = 22;
	localparam int VW           = 40;   // working width of the Q10.30 datapath

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	// exact floor(a / 6) for 32-bit a: (a * DIV6_MUL) >> 34
	localparam logic [31:0] DIV6_MUL = 32'hAAAAAAAB;

	localparam logic signed [32:0] ATAN_TAB [CORDIC_ITERS] = '{
		33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756, 33'sd42667331,
		33'sd21354465, 33'sd10679838, 33'sd5340245, 33'sd2670163, 33'sd1335087,
		33'sd667544, 33'sd333772, 33'sd166886, 33'sd83443, 33'sd41722,
		33'sd20861, 33'sd10430, 33'sd5215, 33'sd2608, 33'sd1304
	};

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [32:0] z;
	} cordic_t;

	// phase -> folded start vector; fold flag is the xor of the top two turn bits
	function automatic cordic_t cordic_init(logic [ANGLE_BITS-1:0] ph);
		logic [31:0] turn;
		cordic_t     c;
		turn = {ph, {(32-ANGLE_BITS){1'b0}}};
		if (turn[31] ^ turn[30])
			turn[31] = ~turn[31];
		c.x = CORDIC_GAIN;
		c.y = '0;
		c.z = {turn[31], turn};
		return c;
	endfunction

	function automatic cordic_t cordic_step(cordic_t c, int i);
		cordic_t n;
		if (!c.z[32]) begin
			n.x = c.x - (c.y >>> i);
			n.y = c.y + (c.x >>> i);
			n.z = c.z - ATAN_TAB[i];
		end else begin
			n.x = c.x + (c.y >>> i);
			n.y = c.y - (c.x >>> i);
			n.z = c.z + ATAN_TAB[i];
		end
		return n;
	endfunction

	// floor(a * b / 2^30); every operand fits in 34 signed bits
	function automatic logic signed [VW-1:0] qmul(logic signed [VW-1:0] a,
		logic signed [VW-1:0] b);
		logic signed [33:0] a_n;
		logic signed [33:0] b_n;
		logic signed [67:0] p;
		a_n = a[33:0];
		b_n = b[33:0];
		p = a_n * b_n;
		return VW'($signed(p[67:TRIG_Q]));
	endfunction

endpackage

// ----- design/klein_bottle_point_eval.sv -----
`timescale 1ns / 1ps
// Klein bottle point evaluator, top level: pipelined CORDIC and formula stages.
// Depends on kbpe_pkg and klein_bottle_point_eval_macros.svh.
//
// Usage:
//  - Input channel (in_valid / in_stall): one word is a pair of 16-bit
//    phases angle_u, angle_v (65536 = one turn).
//  - Output channel (out_valid / out_stall): one word is coord_x, coord_y,
//    coord_z in signed Q16.16, saturated.
//  - Config channel (cfg_valid / cfg_ready / cfg_data): writes the radius
//    (unsigned Q8.8). cfg_ready is always high; write only while idle.
//  - Pipeline: 28 register stages, fold, one per CORDIC iteration (20) and
//    7 of multiply and scaling; out_valid is registered in the last of them.
//  - Throughput: one word per cycle unless the output is held; the 20-stage
//    CORDIC pipes for u and v and the multiplier ranks are fully pipelined.
//  - Stall: when the output word is held by out_stall, the whole pipeline
//    freezes and in_stall is raised; nothing is dropped or repeated.
//    Empty slots still advance while the output is not held.
//  - Reset: arst_n clears all valid bits and sets radius to 1.0.
//
module klein_bottle_point_eval (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [kbpe_pkg::ANGLE_BITS-1:0]     angle_u,
	input  logic [kbpe_pkg::ANGLE_BITS-1:0]     angle_v,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [31:0]                  coord_x,
	output logic signed [31:0]                  coord_y,
	output logic signed [31:0]                  coord_z,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [15:0]                         cfg_data
);

	localparam int N  = kbpe_pkg::CORDIC_ITERS;
	localparam int VW = kbpe_pkg::VW;
	localparam int AB = kbpe_pkg::ANGLE_BITS;

	logic [15:0] radius_q;
	logic        en;

	assign cfg_ready = 1'b1;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd256;
		end else if (cfg_valid && cfg_ready) begin
			radius_q <= cfg_data;
		end
	end

	// ---------------- CORDIC pipes, stage 0 = fold ----------------
	kbpe_pkg::cordic_t u_s [0:N];
	kbpe_pkg::cordic_t v_s [0:N];
	logic              vld_s [0:N];
	logic              negu_s [0:N];
	logic              negv_s [0:N];
	logic              low_s [0:N];   // u below pi

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s[0]    <= kbpe_pkg::cordic_init(angle_u);
			v_s[0]    <= kbpe_pkg::cordic_init(angle_v);
			negu_s[0] <= angle_u[AB-1] ^ angle_u[AB-2];
			negv_s[0] <= angle_v[AB-1] ^ angle_v[AB-2];
			low_s[0]  <= !angle_u[AB-1];
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				u_s[i+1]    <= kbpe_pkg::cordic_step(u_s[i], i);
				v_s[i+1]    <= kbpe_pkg::cordic_step(v_s[i], i);
				negu_s[i+1] <= negu_s[i];
				negv_s[i+1] <= negv_s[i];
				low_s[i+1]  <= low_s[i];
			end
		end
	end

	// ---------------- formula stages ----------------
	logic                  vld_s21, vld_s22, vld_s23, vld_s24, vld_s25, vld_s26, vld_s27;
	logic                  low_s21, low_s22, low_s23;
	logic signed [VW-1:0]  cu_s21, su_s21, cv_s21, sv_s21, r_s21, ops_s21;
	logic signed [VW-1:0]  m1_s22, rcu_s22, rsu_s22, rcv_s22, rsv_s22, su_s22, cv_s22;
	logic signed [VW-1:0]  m1_s23, px_s23, pz_s23, rcv_s23, rsv_s23, su_s23;
	logic signed [VW-1:0]  tx_s24, ty_s24, tz_s24;
	logic signed [56:0]    nx_s25, ny_s25, nz_s25;
	logic [63:0]           px6_s26, py6_s26, pz6_s26;
	logic                  sx_s26, sy_s26, sz_s26;

	logic signed [VW-1:0]  cu_c, su_c, cv_c, sv_c;

	always_comb begin
		cu_c = VW'(u_s[N].x);
		su_c = VW'(u_s[N].y);
		cv_c = VW'(v_s[N].x);
		sv_c = VW'(v_s[N].y);
		if (negu_s[N]) begin
			cu_c = -cu_c;
			su_c = -su_c;
		end
		if (negv_s[N]) begin
			cv_c = -cv_c;
			sv_c = -sv_c;
		end
	end

	// -(radius * term) + 3 * 2^22
	function automatic logic signed [56:0] scale_num(logic [15:0] rad,
		logic signed [VW-1:0] t);
		logic signed [56:0] p;
		p = $signed({1'b0, rad}) * t;
		return (57'sd3 <<< kbpe_pkg::ROUND_SHIFT) - p;
	endfunction

	// floor(n / 2^22) folded to non-negative for the divide by 6
	function automatic logic [31:0] fold_mag(logic signed [56:0] n);
		logic [32:0] m;
		m = n[54:22];
		return m[32] ? ~m[31:0] : m[31:0];
	endfunction

	function automatic logic signed [31:0] finish(logic [63:0] p, logic neg);
		logic signed [32:0] q;
		q = {3'b000, p[63:34]};
		if (neg)
			q = ~q;
		if (q > 33'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (q < -33'sd2147483648)
			return 32'sh80000000;
		return q[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s21 <= 1'b0;
			vld_s22 <= 1'b0;
			vld_s23 <= 1'b0;
			vld_s24 <= 1'b0;
			vld_s25 <= 1'b0;
			vld_s26 <= 1'b0;
			vld_s27 <= 1'b0;
		end else if (en) begin
			vld_s21 <= vld_s[N];
			vld_s22 <= vld_s21;
			vld_s23 <= vld_s22;
			vld_s24 <= vld_s23;
			vld_s25 <= vld_s24;
			vld_s26 <= vld_s25;
			vld_s27 <= vld_s26;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s21: unfold, r = 4 - 2 cu, 1 + su
			cu_s21  <= cu_c;
			su_s21  <= su_c;
			cv_s21  <= cv_c;
			sv_s21  <= sv_c;
			r_s21   <= (VW'(4) <<< kbpe_pkg::TRIG_Q) - (cu_c <<< 1);
			ops_s21 <= (VW'(1) <<< kbpe_pkg::TRIG_Q) + su_c;
			low_s21 <= low_s[N];
			// s22: first multiplier rank
			m1_s22  <= kbpe_pkg::qmul(cu_s21, ops_s21);
			rcu_s22 <= kbpe_pkg::qmul(r_s21, cu_s21);
			rsu_s22 <= kbpe_pkg::qmul(r_s21, su_s21);
			rcv_s22 <= kbpe_pkg::qmul(r_s21, cv_s21);
			rsv_s22 <= kbpe_pkg::qmul(r_s21, sv_s21);
			su_s22  <= su_s21;
			cv_s22  <= cv_s21;
			low_s22 <= low_s21;
			// s23: second multiplier rank
			px_s23  <= kbpe_pkg::qmul(rcu_s22, cv_s22);
			pz_s23  <= kbpe_pkg::qmul(rsu_s22, cv_s22);
			m1_s23  <= m1_s22;
			rcv_s23 <= rcv_s22;
			rsv_s23 <= rsv_s22;
			su_s23  <= su_s22;
			low_s23 <= low_s22;
			// s24: bracket terms, branch on u
			tx_s24  <= VW'(m1_s23 * VW'(6)) + (low_s23 ? px_s23 : -rcv_s23);
			tz_s24  <= (su_s23 <<< 4) + (low_s23 ? pz_s23 : '0);
			ty_s24  <= rsv_s23;
			// s25: radius scaling with rounding offset
			nx_s25  <= scale_num(radius_q, tx_s24);
			ny_s25  <= scale_num(radius_q, ty_s24);
			nz_s25  <= scale_num(radius_q, tz_s24);
			// s26: divide by 6 via reciprocal multiply
			px6_s26 <= {32'b0, fold_mag(nx_s25)} * {32'b0, kbpe_pkg::DIV6_MUL};
			py6_s26 <= {32'b0, fold_mag(ny_s25)} * {32'b0, kbpe_pkg::DIV6_MUL};
			pz6_s26 <= {32'b0, fold_mag(nz_s25)} * {32'b0, kbpe_pkg::DIV6_MUL};
			sx_s26  <= nx_s25[56];
			sy_s26  <= ny_s25[56];
			sz_s26  <= nz_s25[56];
			// s27: output register with saturation
			coord_x <= finish(px6_s26, sx_s26);
			coord_y <= finish(py6_s26, sy_s26);
			coord_z <= finish(pz6_s26, sz_s26);
		end
	end

	assign out_valid = vld_s27;

	`include "klein_bottle_point_eval_macros.svh"

	`KB_ASSERT_NXT(a_entry_valid, en, vld_s[0] == $past(in_valid), "stage 0 valid lost")
	`KB_ASSERT_IMP(a_cos_range, vld_s21,
		(cu_s21 <= 40'sd1073900000) && (cu_s21 >= -40'sd1073900000), "cosine out of range")
	`KB_ASSERT_IMP(a_zero_radius, out_valid && (radius_q == 16'd0),
		(coord_x == 32'sd0) && (coord_y == 32'sd0) && (coord_z == 32'sd0),
		"zero radius gives nonzero point")

endmodule
